// File: rtl/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package wsfr_pkg;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_EXT  = 3'd2,
      PH_MASK = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_BAD_START = 2'd1,
      ERR_LEN_WIDE  = 2'd2
   } error_type;

   localparam logic [7:0] START_TEXT   = 8'h81;
   localparam logic [7:0] START_BINARY = 8'h82;
   localparam logic [6:0] LEN_MASK7    = 7'h7f;
   localparam logic [6:0] LEN_EXT16    = 7'd126;
   localparam logic [6:0] LEN_EXT64    = 7'd127;

   localparam logic [3:0] HDR_SHORT = 4'd6;
   localparam logic [3:0] HDR_EXT16 = 4'd8;
   localparam logic [3:0] HDR_EXT64 = 4'd14;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] HIGH_BYTES  = 4'd4;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  header_count;
      logic [31:0] length_accum;
      logic        length_high_nonzero;
      logic [31:0] mask_key;
      logic [31:0] payload_left;
      logic [1:0]  key_index;
      logic        binary_flag;
      logic [3:0]  header_size;
   } state_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        is_last;
      logic        is_binary;
      logic        is_empty;
      error_type   error_code;
      logic [31:0] payload_length;
      logic [3:0]  header_bytes;
   } result_type;

endpackage

// File: rtl/wsfr_step.sv
// ----------------------------------------------------------------------------
// wsfr_step
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
module wsfr_step (
   input  wsfr_pkg::state_type  cur,
   input  logic [7:0]           in_byte,
   output wsfr_pkg::state_type  nxt,
   output logic                 emit,
   output wsfr_pkg::result_type res
);

   logic [6:0] low7;
   logic [3:0] count_inc;
   logic [3:0] ext_total;
   logic       long_len;
   logic [7:0] key_byte;
   logic [31:0] left_dec;

   assign low7      = in_byte[6:0] & wsfr_pkg::LEN_MASK7;
   assign count_inc = cur.header_count + 4'd1;
   assign long_len  = (cur.header_size == wsfr_pkg::HDR_EXT64);
   assign ext_total = long_len ? wsfr_pkg::EXT64_BYTES : wsfr_pkg::EXT16_BYTES;
   assign left_dec  = cur.payload_left - 32'd1;

   // key byte 0 sits in the top byte of the key
   always_comb begin
      case (cur.key_index)
         2'd0:    key_byte = cur.mask_key[31:24];
         2'd1:    key_byte = cur.mask_key[23:16];
         2'd2:    key_byte = cur.mask_key[15:8];
         default: key_byte = cur.mask_key[7:0];
      endcase
   end

   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      res  = '0;
      unique case (cur.phase)
         wsfr_pkg::PH_HUNT: begin
            if (in_byte == wsfr_pkg::START_TEXT || in_byte == wsfr_pkg::START_BINARY) begin
               nxt.binary_flag         = (in_byte == wsfr_pkg::START_BINARY);
               nxt.length_accum        = '0;
               nxt.length_high_nonzero = 1'b0;
               nxt.header_count        = '0;
               nxt.phase               = wsfr_pkg::PH_LEN;
            end else begin
               emit           = 1'b1;
               res.error_code = wsfr_pkg::ERR_BAD_START;
            end
         end
         wsfr_pkg::PH_LEN: begin
            nxt.header_count = '0;
            if (low7 == wsfr_pkg::LEN_EXT16) begin
               nxt.header_size = wsfr_pkg::HDR_EXT16;
               nxt.phase       = wsfr_pkg::PH_EXT;
            end else if (low7 == wsfr_pkg::LEN_EXT64) begin
               nxt.header_size = wsfr_pkg::HDR_EXT64;
               nxt.phase       = wsfr_pkg::PH_EXT;
            end else begin
               nxt.length_accum = {25'd0, low7};
               nxt.header_size  = wsfr_pkg::HDR_SHORT;
               nxt.phase        = wsfr_pkg::PH_MASK;
            end
         end
         wsfr_pkg::PH_EXT: begin
            // upper half of a 64-bit length is only checked for zero
            if (long_len && cur.header_count < wsfr_pkg::HIGH_BYTES) begin
               if (in_byte != 8'd0) begin
                  nxt.length_high_nonzero = 1'b1;
               end
            end else begin
               nxt.length_accum = {cur.length_accum[23:0], in_byte};
            end
            nxt.header_count = count_inc;
            if (count_inc >= ext_total) begin
               nxt.header_count = '0;
               if (nxt.length_high_nonzero) begin
                  nxt.phase          = wsfr_pkg::PH_HUNT;
                  emit               = 1'b1;
                  res.is_binary      = cur.binary_flag;
                  res.error_code     = wsfr_pkg::ERR_LEN_WIDE;
                  res.payload_length = nxt.length_accum;
                  res.header_bytes   = cur.header_size;
               end else begin
                  nxt.phase = wsfr_pkg::PH_MASK;
               end
            end
         end
         wsfr_pkg::PH_MASK: begin
            nxt.mask_key     = {cur.mask_key[23:0], in_byte};
            nxt.header_count = count_inc;
            if (count_inc >= wsfr_pkg::KEY_BYTES) begin
               nxt.header_count = '0;
               nxt.key_index    = '0;
               nxt.payload_left = cur.length_accum;
               if (cur.length_accum == 32'd0) begin
                  nxt.phase          = wsfr_pkg::PH_HUNT;
                  emit               = 1'b1;
                  res.is_last        = 1'b1;
                  res.is_empty       = 1'b1;
                  res.is_binary      = cur.binary_flag;
                  res.payload_length = cur.length_accum;
                  res.header_bytes   = cur.header_size;
               end else begin
                  nxt.phase = wsfr_pkg::PH_DATA;
               end
            end
         end
         wsfr_pkg::PH_DATA: begin
            nxt.key_index      = cur.key_index + 2'd1;
            nxt.payload_left   = left_dec;
            emit               = 1'b1;
            res.payload_byte   = in_byte ^ key_byte;
            res.is_binary      = cur.binary_flag;
            res.payload_length = cur.length_accum;
            res.header_bytes   = cur.header_size;
            if (left_dec == 32'd0) begin
               res.is_last = 1'b1;
               nxt.phase   = wsfr_pkg::PH_HUNT;
            end
         end
         default: begin
            nxt.phase = wsfr_pkg::PH_HUNT;
         end
      endcase
   end

endmodule

// File: rtl/websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Receive-side WebSocket deframer: header parse, unmasking, one byte a cycle.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle and gives at most one result per byte, in
// the cycle after the byte is taken. Header bytes update the parse state only;
// payload bytes come out unmasked, and bad start bytes, oversized 64-bit
// lengths and empty frames each give a single result. The parse state and the
// result register are updated together from one pass of logic, so a new byte
// is taken every cycle while the result register is empty or being drained;
// the rate is set by that one output register and the downstream ready.
module websocket_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_is_last,
   output logic        rsp_is_binary,
   output logic        rsp_is_empty,
   output logic [1:0]  rsp_error_code,
   output logic [31:0] rsp_payload_length,
   output logic [3:0]  rsp_header_bytes
);

   wsfr_pkg::state_type  state_ff, state_in;
   wsfr_pkg::result_type result_ff, result_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 step_emit;
   logic                 req_take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   wsfr_step u_step (
      .cur     (state_ff),
      .in_byte (req_in_byte),
      .nxt     (state_in),
      .emit    (step_emit),
      .res     (result_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_take && step_emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take && step_emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_byte   = result_ff.payload_byte;
   assign rsp_is_last        = result_ff.is_last;
   assign rsp_is_binary      = result_ff.is_binary;
   assign rsp_is_empty       = result_ff.is_empty;
   assign rsp_error_code     = result_ff.error_code;
   assign rsp_payload_length = result_ff.payload_length;
   assign rsp_header_bytes   = result_ff.header_bytes;

endmodule

// File: tb/websocket_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_checker
// Watches both channels of the frame receiver, predicts and compares results.
// ----------------------------------------------------------------------------
// Every accepted stream byte is run through a local deframer that keeps its
// own parse state; any result it gives is queued. Each accepted result
// transaction is compared field by field with the oldest queued result.
module websocket_frame_checker
   import wsfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_is_last,
   input  logic        rsp_is_binary,
   input  logic        rsp_is_empty,
   input  logic [1:0]  rsp_error_code,
   input  logic [31:0] rsp_payload_length,
   input  logic [3:0]  rsp_header_bytes,
   output int          pending,
   output int          fail_count
);

   phase_type   ph;
   logic [3:0]  hdr_cnt;
   logic [31:0] len_acc;
   logic        len_hi_set;
   logic [31:0] key_word;
   logic [31:0] bytes_left;
   logic [1:0]  key_pos;
   logic        frame_bin;
   logic [3:0]  hdr_size;

   result_type  results_due[$];

   task automatic flag_error(input string msg);
      $display("%0t ns  %s", $time, msg);
      fail_count++;
   endtask

   task automatic clear_parser;
      ph         = PH_HUNT;
      hdr_cnt    = '0;
      len_acc    = '0;
      len_hi_set = 1'b0;
      key_word   = '0;
      bytes_left = '0;
      key_pos    = '0;
      frame_bin  = 1'b0;
      hdr_size   = '0;
      results_due.delete();
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      result_type  r;
      logic [3:0]  ext_n;
      logic [7:0]  key_b;
      r = '0;
      case (ph)
         PH_HUNT: begin
            if (b == START_TEXT || b == START_BINARY) begin
               frame_bin  = (b == START_BINARY);
               len_acc    = '0;
               len_hi_set = 1'b0;
               hdr_cnt    = '0;
               ph         = PH_LEN;
            end else begin
               r.error_code = ERR_BAD_START;
               results_due.push_back(r);
            end
         end
         PH_LEN: begin
            hdr_cnt = '0;
            if ((b[6:0] & LEN_MASK7) == LEN_EXT16) begin
               hdr_size = HDR_EXT16;
               ph       = PH_EXT;
            end else if ((b[6:0] & LEN_MASK7) == LEN_EXT64) begin
               hdr_size = HDR_EXT64;
               ph       = PH_EXT;
            end else begin
               len_acc  = {25'd0, b[6:0]};
               hdr_size = HDR_SHORT;
               ph       = PH_MASK;
            end
         end
         PH_EXT: begin
            ext_n = (hdr_size == HDR_EXT64) ? EXT64_BYTES : EXT16_BYTES;
            // upper half of a 64-bit length only sets the overflow flag
            if (ext_n == EXT64_BYTES && hdr_cnt < HIGH_BYTES) begin
               if (b != 8'd0)
                  len_hi_set = 1'b1;
            end else begin
               len_acc = {len_acc[23:0], b};
            end
            hdr_cnt = hdr_cnt + 4'd1;
            if (hdr_cnt >= ext_n) begin
               hdr_cnt = '0;
               if (len_hi_set) begin
                  ph               = PH_HUNT;
                  r.is_binary      = frame_bin;
                  r.error_code     = ERR_LEN_WIDE;
                  r.payload_length = len_acc;
                  r.header_bytes   = hdr_size;
                  results_due.push_back(r);
               end else begin
                  ph = PH_MASK;
               end
            end
         end
         PH_MASK: begin
            key_word = {key_word[23:0], b};
            hdr_cnt  = hdr_cnt + 4'd1;
            if (hdr_cnt >= KEY_BYTES) begin
               hdr_cnt    = '0;
               key_pos    = '0;
               bytes_left = len_acc;
               if (bytes_left == 32'd0) begin
                  ph               = PH_HUNT;
                  r.is_last        = 1'b1;
                  r.is_binary      = frame_bin;
                  r.is_empty       = 1'b1;
                  r.error_code     = ERR_NONE;
                  r.payload_length = len_acc;
                  r.header_bytes   = hdr_size;
                  results_due.push_back(r);
               end else begin
                  ph = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            key_b      = 8'(key_word >> (8 * (3 - key_pos)));
            key_pos    = key_pos + 2'd1;
            bytes_left = bytes_left - 32'd1;
            r.payload_byte   = b ^ key_b;
            r.is_last        = (bytes_left == 32'd0);
            r.is_binary      = frame_bin;
            r.error_code     = ERR_NONE;
            r.payload_length = len_acc;
            r.header_bytes   = hdr_size;
            results_due.push_back(r);
            if (bytes_left == 32'd0)
               ph = PH_HUNT;
         end
         default: ph = PH_HUNT;
      endcase
   endtask

   task automatic check_result;
      result_type want;
      if (results_due.size() == 0) begin
         flag_error($sformatf("result transaction with none expected (byte %0h err %0d)",
                              rsp_payload_byte, rsp_error_code));
      end else begin
         want = results_due.pop_front();
         if (rsp_payload_byte !== want.payload_byte)
            flag_error($sformatf("payload_byte got %0h want %0h",
                                 rsp_payload_byte, want.payload_byte));
         if (rsp_is_last !== want.is_last)
            flag_error($sformatf("is_last got %0b want %0b", rsp_is_last, want.is_last));
         if (rsp_is_binary !== want.is_binary)
            flag_error($sformatf("is_binary got %0b want %0b",
                                 rsp_is_binary, want.is_binary));
         if (rsp_is_empty !== want.is_empty)
            flag_error($sformatf("is_empty got %0b want %0b", rsp_is_empty, want.is_empty));
         if (rsp_error_code !== want.error_code)
            flag_error($sformatf("error_code got %0d want %0d",
                                 rsp_error_code, want.error_code));
         if (rsp_payload_length !== want.payload_length)
            flag_error($sformatf("payload_length got %0h want %0h",
                                 rsp_payload_length, want.payload_length));
         if (rsp_header_bytes !== want.header_bytes)
            flag_error($sformatf("header_bytes got %0d want %0d",
                                 rsp_header_bytes, want.header_bytes));
      end
   endtask

   // results leave no earlier than the cycle after their byte, so check before predicting
   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
      end else begin
         if (rsp_valid && rsp_ready)
            check_result();
         if (req_valid && req_ready)
            deframe_byte(req_in_byte);
      end
      pending = results_due.size();
   end

endmodule

// File: tb/tb_websocket_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_receiver
// Stream stimulus and verdict for the WebSocket frame receiver.
// ----------------------------------------------------------------------------
// Sends a short directed byte stream (bad start bytes, empty frames, a 64-bit
// length with its upper half set) and then random frames of every header
// form, mixed with stray bytes and oversized lengths. Both sides stall at
// random, except for one calm stretch. Checking is left to the checker.
module tb_websocket_frame_receiver;
   import wsfr_pkg::*;

   typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_is_last;
   logic        rsp_is_binary;
   logic        rsp_is_empty;
   logic [1:0]  rsp_error_code;
   logic [31:0] rsp_payload_length;
   logic [3:0]  rsp_header_bytes;

   int          pending;
   int          fail_count;
   int          sent  = 0;
   logic        calm  = 1'b0;

   websocket_frame_receiver dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_is_last        (rsp_is_last),
      .rsp_is_binary      (rsp_is_binary),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_error_code     (rsp_error_code),
      .rsp_payload_length (rsp_payload_length),
      .rsp_header_bytes   (rsp_header_bytes)
   );

   websocket_frame_checker u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_is_last        (rsp_is_last),
      .rsp_is_binary      (rsp_is_binary),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_error_code     (rsp_error_code),
      .rsp_payload_length (rsp_payload_length),
      .rsp_header_bytes   (rsp_header_bytes),
      .pending            (pending),
      .fail_count         (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
   end

   // called and returns at a falling edge; valid stays high into the next byte
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic bin, input logic mask_bit,
                             input len_form_type form, input logic [63:0] len);
      send_byte(bin ? START_BINARY : START_TEXT);
      case (form)
         FORM_SHORT: send_byte({mask_bit, len[6:0]});
         FORM_EXT16: begin
            send_byte({mask_bit, LEN_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            send_byte({mask_bit, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
               send_byte(len[8*i +: 8]);
         end
      endcase
      // an oversized length ends the frame before the key
      if (len[63:32] == 32'd0) begin
         repeat (4) send_byte(8'($urandom));
         repeat (len[31:0]) send_byte(8'($urandom));
      end
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int           pick;
      int           wait_cycles;
      logic         mid_drained;
      logic [7:0]   b;
      logic [31:0]  upper;
      logic [63:0]  len;
      len_form_type form;

      mid_drained = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: stray bytes, empty frames, oversized 64-bit length
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(1'b0, 1'b0, FORM_SHORT, 64'd0);
      send_frame(1'b0, 1'b1, FORM_EXT16, 64'd0);
      send_frame(1'b1, 1'b1, FORM_EXT64, {32'h0000_0100, 32'hFFFF_FFFF});
      send_byte(8'h80);
      drain_results();

      while (sent < 750) begin
         calm = (sent >= 300 && sent < 420);
         if (!mid_drained && sent >= 520) begin
            drain_results();
            mid_drained = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 12) begin
            repeat ($urandom_range(1, 3)) begin
               do b = 8'($urandom); while (b == START_TEXT || b == START_BINARY);
               send_byte(b);
            end
         end else if (pick < 20) begin
            upper = $urandom;
            if (upper == 32'd0)
               upper = 32'd1 << $urandom_range(31);
            send_frame(1'($urandom_range(1)), 1'($urandom_range(1)), FORM_EXT64,
                       {upper, 32'($urandom)});
         end else begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               form = FORM_SHORT;
               case ($urandom_range(9))
                  0:       len = 64'd0;
                  1:       len = 64'($urandom_range(120, 125));
                  default: len = 64'($urandom_range(1, 12));
               endcase
            end else if (pick < 85) begin
               form = FORM_EXT16;
               len  = ($urandom_range(11) == 0) ? 64'($urandom_range(256, 262))
                                                : 64'($urandom_range(0, 20));
            end else begin
               form = FORM_EXT64;
               len  = 64'($urandom_range(0, 20));
            end
            send_frame(1'($urandom_range(1)), 1'($urandom_range(1)), form, len);
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 20000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (20) @(negedge clock);
      if (pending == 0 && fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: sim.f
rtl/wsfr_pkg.sv
rtl/wsfr_step.sv
rtl/websocket_frame_receiver.sv
tb/websocket_frame_checker.sv
tb/tb_websocket_frame_receiver.sv
